@@ design/tcsc_pkg.sv @@
package tcsc_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] MagicWord = 32'h4D4B5345;
  localparam logic [63:0] MaxElems = 64'h1FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_DIM = 2'd1;
  localparam logic [1:0] KIND_ELEM = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_SHORT = 3'd1;
  localparam logic [2:0] ST_CRC = 3'd2;
  localparam logic [2:0] ST_MAGIC = 3'd3;
  localparam logic [2:0] ST_VERSION = 3'd4;
  localparam logic [2:0] ST_DTYPE = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;
  localparam logic [2:0] ST_TRAILING = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] value;
    logic [31:0] record_index;
    logic [2:0]  status;
    logic        final_item;
  } out_word_t;

endpackage

@@ design/tcsc_stream_if.sv @@
interface tcsc_in_if;
  logic                valid;
  logic                ready;
  tcsc_pkg::in_word_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tcsc_out_if;
  logic                valid;
  logic                ready;
  tcsc_pkg::out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ design/tensor_checkpoint_stream_checker_unit.sv @@
// Checkpoint stream checker.
// Input channel in_ch: one file byte per word with last_byte set on the
// final byte. Output channel out_ch: name bytes, dimensions, element words
// and, after the final byte, one status word with final_item set.
// Each input word passes through a small sequencer: the CRC takes eight
// one-bit steps on a dedicated shift unit, and a nonzero dimension word on
// a live product drives a shift-add multiplier, one multiplier bit per
// cycle (64 steps) with an overflow check. The first four bytes of a file
// only fill the window. After that each byte goes through the CRC steps
// and the parser before its result word is handed to the output register;
// the sequencer takes no new byte until it is done with the current one.
// The final byte is followed by the status word once the output register
// is free. Results leave through a one-word output register; the sequencer
// waits on it only when it has a new word to hand over, so a stalled
// receiver stalls the block after at most one held word.
// Synchronous reset (rst) clears all control state and returns the parser
// to the magic phase; after the status word the block resets itself for
// the next file.
module tensor_checkpoint_stream_checker_unit (
  input logic clk,
  input logic rst,
  tcsc_in_if.sink in_ch,
  tcsc_out_if.source out_ch
);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_VERSION, PH_COUNT, PH_FLAGS, PH_NAMELEN, PH_NAME,
    PH_NDIMS, PH_DIM, PH_DTYPE, PH_ELEM, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CRC, S_PARSE, S_MUL, S_EMIT, S_STATUS
  } seq_t;

  seq_t        seq;
  phase_t      phase;
  logic [7:0]  win [4];
  logic [2:0]  fill;
  logic [31:0] crc;
  logic [4:0]  total;
  logic [2:0]  fcount;
  logic [63:0] acc;
  logic [31:0] records_left;
  logic [31:0] cur_rec;
  logic [31:0] name_left;
  logic [31:0] dims_left;
  logic [63:0] prod;
  logic        zero_seen;
  logic [61:0] elems_left;
  logic [2:0]  perr;
  logic [7:0]  pbyte;
  logic        plast;
  logic [2:0]  step;
  logic [63:0] mul_a;
  logic [63:0] mul_sum;
  logic [5:0]  mul_cnt;
  logic        mul_ovf;
  logic        pend_emit;
  tcsc_pkg::out_word_t pend;
  logic        ovalid;
  tcsc_pkg::out_word_t oword;

  assign in_ch.ready = (seq == S_IDLE);
  assign out_ch.valid = ovalid;
  assign out_ch.payload = oword;

  logic        out_free;
  assign out_free = !ovalid || out_ch.ready;

  // load the output register from the emit or status step
  logic        out_load;
  assign out_load = out_free && ((seq == S_EMIT && pend_emit) || seq == S_STATUS);

  logic [63:0] acc_in;
  logic [31:0] crc_step;
  logic [64:0] mul_add;
  logic [63:0] a_dbl;
  logic [2:0]  final_status;
  logic [31:0] stored;

  always_comb begin
    acc_in = acc | ({56'd0, pbyte} << {fcount, 3'b000});
    crc_step = (crc >> 1) ^ (crc[0] ? tcsc_pkg::CrcPoly : 32'd0);
    mul_add = {1'b0, mul_sum} + {1'b0, mul_a};
    a_dbl = mul_a << 1;
    stored = {win[3], win[2], win[1], win[0]};
    if (total < 5'd16) final_status = tcsc_pkg::ST_SHORT;
    else if (stored != ~crc) final_status = tcsc_pkg::ST_CRC;
    else if (perr != tcsc_pkg::ST_OK) final_status = perr;
    else if (phase != PH_DONE) final_status = tcsc_pkg::ST_SHORT;
    else final_status = tcsc_pkg::ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= S_IDLE;
      phase <= PH_MAGIC;
      fill <= '0;
      crc <= '1;
      total <= '0;
      fcount <= '0;
      acc <= '0;
      records_left <= '0;
      cur_rec <= '0;
      name_left <= '0;
      dims_left <= '0;
      prod <= 64'd1;
      zero_seen <= 1'b0;
      elems_left <= '0;
      perr <= tcsc_pkg::ST_OK;
      ovalid <= 1'b0;
      pend_emit <= 1'b0;
      plast <= 1'b0;
    end else begin
      if (out_load) ovalid <= 1'b1;
      else if (ovalid && out_ch.ready) ovalid <= 1'b0;
      unique case (seq)
        S_IDLE: begin
          if (in_ch.valid) begin
            plast <= in_ch.payload.last_byte;
            pend_emit <= 1'b0;
            if (total < 5'd16) total <= total + 5'd1;
            if (fill < 3'd4) begin
              win[fill[1:0]] <= in_ch.payload.data_byte;
              fill <= fill + 3'd1;
              seq <= S_EMIT;
            end else begin
              // shift the window; the oldest byte goes to CRC and parser
              pbyte <= win[0];
              win[0] <= win[1];
              win[1] <= win[2];
              win[2] <= win[3];
              win[3] <= in_ch.payload.data_byte;
              crc <= crc ^ {24'd0, win[0]};
              step <= '0;
              seq <= S_CRC;
            end
          end
        end
        S_CRC: begin
          crc <= crc_step;
          step <= step + 3'd1;
          if (step == 3'd7) seq <= S_PARSE;
        end
        S_PARSE: begin
          // a nonzero dimension on a live product goes through the multiplier
          if (phase == PH_DIM && fcount == 3'd7 && !zero_seen && prod != 64'd0 &&
              acc_in != 64'd0) seq <= S_MUL;
          else seq <= S_EMIT;
          unique case (phase)
            PH_MAGIC, PH_VERSION, PH_COUNT, PH_FLAGS, PH_NAMELEN, PH_NDIMS:
            begin
              if (fcount != 3'd3) begin
                acc <= acc_in;
                fcount <= fcount + 3'd1;
              end else begin
                acc <= '0;
                fcount <= '0;
                unique case (phase)
                  PH_MAGIC: begin
                    if (acc_in[31:0] != tcsc_pkg::MagicWord) begin
                      perr <= tcsc_pkg::ST_MAGIC;
                      phase <= PH_ERROR;
                    end else phase <= PH_VERSION;
                  end
                  PH_VERSION: begin
                    if (acc_in[31:0] != 32'd1) begin
                      perr <= tcsc_pkg::ST_VERSION;
                      phase <= PH_ERROR;
                    end else phase <= PH_COUNT;
                  end
                  PH_COUNT: begin
                    records_left <= acc_in[31:0];
                    phase <= PH_FLAGS;
                  end
                  PH_FLAGS: phase <= (records_left == 32'd0) ? PH_DONE : PH_NAMELEN;
                  PH_NAMELEN: begin
                    name_left <= acc_in[31:0];
                    phase <= (acc_in[31:0] == 32'd0) ? PH_NDIMS : PH_NAME;
                  end
                  default: begin
                    dims_left <= acc_in[31:0];
                    prod <= 64'd1;
                    zero_seen <= 1'b0;
                    phase <= (acc_in[31:0] == 32'd0) ? PH_DTYPE : PH_DIM;
                  end
                endcase
              end
            end
            PH_NAME: begin
              pend <= '{tcsc_pkg::KIND_NAME, {56'd0, pbyte}, cur_rec,
                        tcsc_pkg::ST_OK, 1'b0};
              pend_emit <= 1'b1;
              name_left <= name_left - 32'd1;
              if (name_left == 32'd1) phase <= PH_NDIMS;
            end
            PH_DIM, PH_ELEM: begin
              if (fcount != 3'd7) begin
                acc <= acc_in;
                fcount <= fcount + 3'd1;
              end else begin
                acc <= '0;
                fcount <= '0;
                pend_emit <= 1'b1;
                if (phase == PH_DIM) begin
                  pend <= '{tcsc_pkg::KIND_DIM, acc_in, cur_rec,
                            tcsc_pkg::ST_OK, 1'b0};
                  dims_left <= dims_left - 32'd1;
                  if (dims_left == 32'd1) phase <= PH_DTYPE;
                  if (!zero_seen && prod != 64'd0) begin
                    if (acc_in == 64'd0) begin
                      zero_seen <= 1'b1;
                      prod <= '0;
                    end else begin
                      // product = prod * acc_in, one multiplier bit a step
                      mul_a <= prod;
                      mul_sum <= '0;
                      mul_cnt <= '0;
                      mul_ovf <= 1'b0;
                    end
                  end
                end else begin
                  pend <= '{tcsc_pkg::KIND_ELEM, acc_in, cur_rec,
                            tcsc_pkg::ST_OK, 1'b0};
                  elems_left <= elems_left - 62'd1;
                  if (elems_left == 62'd1) begin
                    cur_rec <= cur_rec + 32'd1;
                    records_left <= records_left - 32'd1;
                    phase <= (records_left == 32'd1) ? PH_DONE : PH_NAMELEN;
                  end
                end
              end
            end
            PH_DTYPE: begin
              if (pbyte != 8'd0) begin
                perr <= tcsc_pkg::ST_DTYPE;
                phase <= PH_ERROR;
              end else if (!zero_seen && (prod == 64'd0 || prod > tcsc_pkg::MaxElems))
              begin
                perr <= tcsc_pkg::ST_OVERFLOW;
                phase <= PH_ERROR;
              end else if (zero_seen) begin
                cur_rec <= cur_rec + 32'd1;
                records_left <= records_left - 32'd1;
                phase <= (records_left == 32'd1) ? PH_DONE : PH_NAMELEN;
              end else begin
                elems_left <= prod[61:0];
                phase <= PH_ELEM;
              end
            end
            PH_DONE: begin
              perr <= tcsc_pkg::ST_TRAILING;
              phase <= PH_ERROR;
            end
            default: ;
          endcase
        end
        S_MUL: begin
          // acc holds zero here; multiplier bits come from pend.value
          if (pend.value[mul_cnt]) mul_sum <= mul_add[63:0];
          if ((pend.value[mul_cnt] && mul_add[64]) ||
              (mul_a[63] && (pend.value >> mul_cnt) > 64'd1)) mul_ovf <= 1'b1;
          mul_a <= a_dbl;
          mul_cnt <= mul_cnt + 6'd1;
          if (mul_cnt == 6'd63) begin
            prod <= (mul_ovf || (pend.value[63] && mul_add[64])) ? 64'd0 :
                    (pend.value[63] ? mul_add[63:0] : mul_sum);
            seq <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!pend_emit || out_free) begin
            if (pend_emit) begin
              oword <= pend;
              pend_emit <= 1'b0;
            end
            seq <= plast ? S_STATUS : S_IDLE;
          end
        end
        S_STATUS: begin
          if (out_free) begin
            oword <= '{tcsc_pkg::KIND_STATUS, 64'd0, cur_rec, final_status, 1'b1};
            // return to reset values for the next file
            phase <= PH_MAGIC;
            fill <= '0;
            crc <= '1;
            total <= '0;
            fcount <= '0;
            acc <= '0;
            records_left <= '0;
            cur_rec <= '0;
            name_left <= '0;
            dims_left <= '0;
            prod <= 64'd1;
            zero_seen <= 1'b0;
            elems_left <= '0;
            perr <= tcsc_pkg::ST_OK;
            plast <= 1'b0;
            seq <= S_IDLE;
          end
        end
        default: seq <= S_IDLE;
      endcase
    end
  end

  // hold the result word while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !out_ch.ready |=> ovalid && $stable(oword))
    else $error("output word dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("accepted a byte while busy");
  a_fin: assert property (@(posedge clk) disable iff (rst)
    ovalid && oword.final_item |-> oword.kind == tcsc_pkg::KIND_STATUS)
    else $error("final flag on a field word");
  a_err: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |-> perr != tcsc_pkg::ST_OK)
    else $error("error phase without code");

endmodule
